@@ rtl/set_pkg.sv @@
package set_pkg;

  localparam int unsigned Entries    = 1024;
  localparam int unsigned TokenWidth = 64;
  localparam int unsigned UserWidth  = 32;
  localparam int unsigned IdxW       = $clog2(Entries);
  localparam int unsigned CntW       = 11;
  localparam int unsigned RegW       = 20;
  localparam int unsigned TimeW      = 47;
  localparam int unsigned ExpW       = 48;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [RegW-1:0] MinTtlReset = 20'd1;
  localparam logic [RegW-1:0] MaxTtlReset = 20'd604800;

  localparam logic [CfgIdxW-1:0] CfgMinTtl = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxTtl = 1'd1;

  localparam logic [2:0] OpCreate   = 3'd0;
  localparam logic [2:0] OpValidate = 3'd1;
  localparam logic [2:0] OpRefresh  = 3'd2;
  localparam logic [2:0] OpDestroy  = 3'd3;
  localparam logic [2:0] OpPurge    = 3'd4;
  localparam logic [2:0] OpRevoke   = 3'd5;
  localparam logic [2:0] OpCount    = 3'd6;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StBadUser = 3'd1;
  localparam logic [2:0] StFull    = 3'd2;
  localparam logic [2:0] StDup     = 3'd3;
  localparam logic [2:0] StMissing = 3'd4;
  localparam logic [2:0] StExpired = 3'd5;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] session_token;
    logic [31:0] user_number;
    logic [31:0] lifetime;
    logic [46:0] current_time;
  } set_req_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [CntW-1:0] entry_count;
  } set_rsp_t;

  // One stored slot together with its valid bit.
  typedef struct packed {
    logic                  valid;
    logic [TokenWidth-1:0] token;
    logic [UserWidth-1:0]  user;
    logic [RegW-1:0]       lifetime;
    logic [ExpW-1:0]       expiry;
  } set_entry_t;

endpackage

@@ rtl/set_store.sv @@
module set_store
  import set_pkg::*;
(
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  set_entry_t          wdata_i,
  input  logic [IdxW-1:0]     raddr_i,
  output set_entry_t          rdata_o
);

  set_entry_t mem_q [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/session_expiry_table.sv @@
// Channel  | Ports                               | Direction
// command  | start_i, req_i (busy_o out)         | in
// result   | done_o, rsp_o                       | out
// config   | cfg_we_i, cfg_idx_i, cfg_data_i     | in
//
// Each command takes one table sweep, then the decide state, the write state
// for create and refresh, and the done state, which registers the result
// strobe; the next command is taken at the edge that ends the strobe. The
// single read port of the entry memory makes every command sweep the table.
// After reset a clearing pass zeroes every slot while busy_o is high. The
// result is shown for one cycle with done_o; the receiver cannot stall.
module session_expiry_table
  import set_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  set_req_t        req_i,
  output logic            busy_o,
  output logic            done_o,
  output set_rsp_t        rsp_o,
  input  logic            cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RegW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_WRITE,
    S_DONE
  } state_e;

  state_e            state_q;
  set_req_t          req_q;
  logic [RegW-1:0]   min_ttl_q, max_ttl_q;
  // Sweep address counter; the extra bit marks the end of the sweep.
  logic [IdxW:0]     addr_q;
  logic              rd_vld_q;
  logic [IdxW-1:0]   rd_idx_q;
  logic              hit_q, free_q;
  logic [IdxW-1:0]   hit_idx_q, free_idx_q;
  logic [CntW-1:0]   cnt_q;
  logic [2:0]        status_q;
  set_entry_t        hit_ent_q;
  logic [RegW-1:0]   ttl_q;

  logic              we;
  logic [IdxW-1:0]   waddr;
  set_entry_t        wdata;
  set_entry_t        rdata;

  set_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (addr_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  logic [TokenWidth-1:0] tok;
  logic [UserWidth-1:0]  usr;
  logic [ExpW-1:0]       now;
  logic                  slot_vld, expired, tok_hit, hit_expired;
  logic                  drop_scan, drop_hit;

  assign tok         = req_q.session_token[TokenWidth-1:0];
  assign usr         = req_q.user_number[UserWidth-1:0];
  assign now         = {1'b0, req_q.current_time};
  assign slot_vld    = rd_vld_q && rdata.valid;
  assign expired     = now >= rdata.expiry;
  assign tok_hit     = slot_vld && (rdata.token == tok);
  assign hit_expired = now >= hit_ent_q.expiry;

  // Slot just read is removed by purge, count or revoke during the sweep.
  always_comb begin
    drop_scan = 1'b0;
    if (req_q.opcode inside {OpPurge, OpCount}) begin
      drop_scan = slot_vld && expired;
    end else if (req_q.opcode == OpRevoke) begin
      drop_scan = slot_vld && (usr != '0) && (rdata.user == usr);
    end
  end

  // The matched slot is removed by destroy, or by a lookup that finds it
  // expired.
  always_comb begin
    drop_hit = 1'b0;
    if (hit_q) begin
      if (req_q.opcode == OpDestroy) begin
        drop_hit = 1'b1;
      end else if (req_q.opcode inside {OpValidate, OpRefresh}) begin
        drop_hit = hit_expired;
      end
    end
  end

  // The clamp compares the requested lifetime with the registers in turn.
  logic [RegW-1:0] ttl_clamped;
  always_comb begin
    if (req_q.lifetime < {12'd0, min_ttl_q}) begin
      ttl_clamped = min_ttl_q;
    end else if (req_q.lifetime > {12'd0, max_ttl_q}) begin
      ttl_clamped = max_ttl_q;
    end else begin
      ttl_clamped = req_q.lifetime[RegW-1:0];
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = hit_idx_q;
    wdata = hit_ent_q;
    unique case (state_q)
      S_CLEAR: begin
        we    = !addr_q[IdxW];
        waddr = addr_q[IdxW-1:0];
        wdata = '0;
      end
      S_SCAN: begin
        we          = drop_scan;
        waddr       = rd_idx_q;
        wdata       = rdata;
        wdata.valid = 1'b0;
      end
      S_DECIDE: begin
        we          = drop_hit;
        wdata.valid = 1'b0;
      end
      S_WRITE: begin
        we          = 1'b1;
        wdata.valid = 1'b1;
        if (req_q.opcode == OpCreate) begin
          waddr          = free_idx_q;
          wdata.token    = tok;
          wdata.user     = usr;
          wdata.lifetime = ttl_q;
          wdata.expiry   = now + {28'd0, ttl_q};
        end else begin
          wdata.expiry = now + {28'd0, hit_ent_q.lifetime};
        end
      end
      default: ;
    endcase
  end

  assign busy_o = state_q != S_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      req_q      <= '0;
      min_ttl_q  <= MinTtlReset;
      max_ttl_q  <= MaxTtlReset;
      addr_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      hit_q      <= 1'b0;
      free_q     <= 1'b0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
      cnt_q      <= '0;
      status_q   <= StOk;
      hit_ent_q  <= '0;
      ttl_q      <= '0;
      done_o     <= 1'b0;
      rsp_o      <= '0;
    end else begin
      done_o   <= 1'b0;
      rd_vld_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMinTtl: min_ttl_q <= cfg_data_i;
          CfgMaxTtl: max_ttl_q <= cfg_data_i;
          default:   ;
        endcase
      end
      unique case (state_q)
        // Clearing pass: one slot zeroed per cycle after reset.
        S_CLEAR: begin
          if (addr_q[IdxW]) begin
            state_q <= S_IDLE;
          end else begin
            addr_q <= addr_q + (IdxW+1)'(1);
          end
        end
        S_IDLE: begin
          if (start_i) begin
            req_q    <= req_i;
            addr_q   <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            cnt_q    <= '0;
            status_q <= StOk;
            state_q  <= S_SCAN;
          end
        end
        // Single sweep: lookup, free slot, purge, revoke and active count.
        S_SCAN: begin
          if (!addr_q[IdxW]) begin
            addr_q   <= addr_q + (IdxW+1)'(1);
            rd_vld_q <= 1'b1;
            rd_idx_q <= addr_q[IdxW-1:0];
          end
          if (rd_vld_q) begin
            if (!rdata.valid && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
            if (tok_hit && !hit_q) begin
              hit_q     <= 1'b1;
              hit_idx_q <= rd_idx_q;
              hit_ent_q <= rdata;
            end
            // Count tallies the slots that survive the purge.
            if (drop_scan) begin
              if (req_q.opcode != OpCount) cnt_q <= cnt_q + CntW'(1);
            end else if (req_q.opcode == OpCount && slot_vld) begin
              cnt_q <= cnt_q + CntW'(1);
            end
          end
          if (addr_q[IdxW] && !rd_vld_q) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_DONE;
          ttl_q   <= ttl_clamped;
          unique case (req_q.opcode)
            OpCreate: begin
              if (usr == '0) status_q <= StBadUser;
              else if (!free_q) status_q <= StFull;
              else if (hit_q) status_q <= StDup;
              else state_q <= S_WRITE;
            end
            OpValidate, OpRefresh: begin
              if (!hit_q) status_q <= StMissing;
              else if (hit_expired) status_q <= StExpired;
              else if (req_q.opcode == OpRefresh) state_q <= S_WRITE;
            end
            OpDestroy: begin
              if (!hit_q) status_q <= StMissing;
            end
            OpRevoke: begin
              if (usr == '0) status_q <= StBadUser;
            end
            default: ;
          endcase
        end
        S_WRITE: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          done_o            <= 1'b1;
          rsp_o.status      <= status_q;
          rsp_o.entry_count <= (status_q == StOk &&
                                (req_q.opcode == OpPurge || req_q.opcode == OpRevoke ||
                                 req_q.opcode == OpCount)) ? cnt_q : '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ dv/tb_session_expiry_table.sv @@
module tb_session_expiry_table;
  import set_pkg::*;

  // Opcode 7 has no name in the package; the block must treat it as a no-op.
  localparam logic [2:0] OpUnused = 3'd7;
  localparam int unsigned TokPool = 24;
  localparam int unsigned UsrPool = 6;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  set_req_t         req_i = '0;
  logic             busy_o;
  logic             done_o;
  set_rsp_t         rsp_o;
  logic             cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0]  cfg_data_i = '0;

  session_expiry_table dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the session table and of the TTL bounds. The valid bits
  // match the block's reset; the other fields are only read for valid slots.
  bit              slot_valid [Entries];
  logic [63:0]     slot_token [Entries];
  logic [31:0]     slot_user  [Entries];
  logic [RegW-1:0] slot_ttl   [Entries];
  logic [ExpW-1:0] slot_expiry[Entries];
  logic [RegW-1:0] ttl_floor = MinTtlReset;
  logic [RegW-1:0] ttl_ceil  = MaxTtlReset;

  // Responses still owed by the block, oldest first.
  set_rsp_t        pending_rsp[$];
  int              fail_count = 0;
  int              idle_pct = 0;

  // Stimulus context: token and user pools let lookups and revokes hit.
  logic [63:0]     tok_pool[TokPool];
  logic [31:0]     usr_pool[UsrPool];
  logic [46:0]     clock_now = '0;

  function automatic int find_token(logic [63:0] tok);
    for (int i = 0; i < Entries; i++) begin
      if (slot_valid[i] && slot_token[i] == tok) return i;
    end
    return -1;
  endfunction

  function automatic int drop_expired(logic [46:0] now);
    int n;
    n = 0;
    for (int i = 0; i < Entries; i++) begin
      if (slot_valid[i] && {1'b0, now} >= slot_expiry[i]) begin
        slot_valid[i] = 1'b0;
        n++;
      end
    end
    return n;
  endfunction

  // Applies one command to the shadow table and returns the response the
  // block should give for it.
  function automatic set_rsp_t apply_command(set_req_t r);
    set_rsp_t        res;
    int              slot;
    int              n;
    logic [31:0]     ttl;
    res = '{status: StOk, entry_count: '0};
    n = 0;
    case (r.opcode)
      OpCreate: begin
        if (r.user_number == '0) begin
          res.status = StBadUser;
        end else begin
          slot = -1;
          for (int i = 0; i < Entries; i++) begin
            if (!slot_valid[i]) begin
              slot = i;
              break;
            end
          end
          ttl = r.lifetime;
          if (ttl < {12'd0, ttl_floor}) ttl = {12'd0, ttl_floor};
          else if (ttl > {12'd0, ttl_ceil}) ttl = {12'd0, ttl_ceil};
          if (slot < 0) begin
            res.status = StFull;
          end else if (find_token(r.session_token) >= 0) begin
            res.status = StDup;
          end else begin
            slot_valid[slot]  = 1'b1;
            slot_token[slot]  = r.session_token;
            slot_user[slot]   = r.user_number;
            slot_ttl[slot]    = ttl[RegW-1:0];
            slot_expiry[slot] = {1'b0, r.current_time} + ExpW'(ttl[RegW-1:0]);
          end
        end
      end
      OpValidate, OpRefresh: begin
        slot = find_token(r.session_token);
        if (slot < 0) begin
          res.status = StMissing;
        end else if ({1'b0, r.current_time} >= slot_expiry[slot]) begin
          slot_valid[slot] = 1'b0;
          res.status = StExpired;
        end else if (r.opcode == OpRefresh) begin
          slot_expiry[slot] = {1'b0, r.current_time} + ExpW'(slot_ttl[slot]);
        end
      end
      OpDestroy: begin
        slot = find_token(r.session_token);
        if (slot < 0) res.status = StMissing;
        else slot_valid[slot] = 1'b0;
      end
      OpPurge: begin
        n = drop_expired(r.current_time);
      end
      OpRevoke: begin
        if (r.user_number == '0) begin
          res.status = StBadUser;
        end else begin
          for (int i = 0; i < Entries; i++) begin
            if (slot_valid[i] && slot_user[i] == r.user_number) begin
              slot_valid[i] = 1'b0;
              n++;
            end
          end
        end
      end
      OpCount: begin
        void'(drop_expired(r.current_time));
        for (int i = 0; i < Entries; i++) begin
          if (slot_valid[i]) n++;
        end
      end
      default: ;
    endcase
    res.entry_count = CntW'(n);
    return res;
  endfunction

  // Sends one command. It is called at a rising edge (or before the first
  // one) and returns at the edge where the transfer happens. start_i gets
  // only one assignment per step, so back-to-back commands keep it high.
  task automatic send_command(set_req_t r);
    int gap;
    gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    // busy_o only moves on rising edges, so its value at the falling edge is
    // what the block sees at the next rising edge.
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    pending_rsp.push_back(apply_command(r));
  endtask

  // Lowers start_i and waits for every owed response, so that the block is
  // idle afterwards.
  task automatic wait_drained();
    start_i <= 1'b0;
    wait (pending_rsp.size() == 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_bound(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx == CfgMinTtl) ttl_floor = val;
    else ttl_ceil = val;
    @(posedge clk_i);
  endtask

  function automatic set_req_t make_cmd(logic [2:0] op, logic [63:0] tok,
                                        logic [31:0] usr, logic [31:0] ttl,
                                        logic [46:0] now);
    set_req_t r;
    r.opcode        = op;
    r.session_token = tok;
    r.user_number   = usr;
    r.lifetime      = ttl;
    r.current_time  = now;
    return r;
  endfunction

  // Every response is checked at the edge that ends its one-cycle strobe.
  always @(posedge clk_i) begin
    set_rsp_t want;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: response with none owed: status %0d count %0d", $time,
                 rsp_o.status, rsp_o.entry_count);
        fail_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   rsp_o.status);
          fail_count++;
        end
        if (rsp_o.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time,
                   want.entry_count, rsp_o.entry_count);
          fail_count++;
        end
      end
    end
  end

  // Hand-picked commands: each opcode, every status code but full, field extremes,
  // expired duplicates, refresh versus validate, and time going backwards.
  task automatic test_directed();
    logic [63:0] t_all;
    t_all = '1;
    send_command(make_cmd(OpCreate, 64'h1, 32'd0, 32'd10, 47'd0));
    send_command(make_cmd(OpCreate, 64'h0, 32'hFFFF_FFFF, 32'd0, 47'd0));
    send_command(make_cmd(OpCreate, t_all, 32'd7, 32'hFFFF_FFFF, 47'd0));
    send_command(make_cmd(OpCreate, 64'h0, 32'd9, 32'd5, 47'd1));
    send_command(make_cmd(OpCreate, 64'h55, 32'd7, 32'd5, 47'd1));
    send_command(make_cmd(OpValidate, 64'h55, 32'd0, 32'd0, 47'd4));
    send_command(make_cmd(OpRefresh, 64'h55, 32'd0, 32'd0, 47'd5));
    send_command(make_cmd(OpValidate, 64'h55, 32'd0, 32'd0, 47'd9));
    send_command(make_cmd(OpValidate, 64'h55, 32'd0, 32'd0, 47'd10));
    send_command(make_cmd(OpValidate, 64'h55, 32'd0, 32'd0, 47'd10));
    send_command(make_cmd(OpRefresh, 64'h0, 32'd0, 32'd0, 47'd20));
    send_command(make_cmd(OpDestroy, 64'h77, 32'd0, 32'd0, 47'd20));
    send_command(make_cmd(OpCreate, 64'h66, 32'd9, 32'd3, 47'd20));
    // The token below has expired but still counts as a duplicate.
    send_command(make_cmd(OpCreate, 64'h66, 32'd9, 32'd3, 47'd30));
    send_command(make_cmd(OpCount, 64'h0, 32'd0, 32'd0, 47'd30));
    send_command(make_cmd(OpUnused, t_all, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1));
    send_command(make_cmd(OpRevoke, 64'h0, 32'd0, 32'd0, 47'd30));
    send_command(make_cmd(OpRevoke, 64'h0, 32'hFFFF_FFFF, 32'd0, 47'd30));
    send_command(make_cmd(OpCreate, 64'h88, 32'd9, 32'd100, 47'd30));
    // Time runs backwards here; values are compared as given.
    send_command(make_cmd(OpValidate, 64'h88, 32'd0, 32'd0, 47'd2));
    send_command(make_cmd(OpCreate, 64'h99, 32'd9, 32'd100, '1));
    send_command(make_cmd(OpRefresh, 64'h99, 32'd0, 32'd0, 47'h7FFF_FFFF_FF00));
    send_command(make_cmd(OpRevoke, 64'h0, 32'd9, 32'd0, 47'd40));
    send_command(make_cmd(OpPurge, 64'h0, 32'd0, 32'd0, '1));
    send_command(make_cmd(OpDestroy, t_all, 32'd0, 32'd0, '1));
    wait_drained();
  endtask

  // Clamp behavior at the register extremes, including a floor above the
  // ceiling, where every lifetime that passes the floor becomes the ceiling.
  task automatic test_ttl_bounds();
    logic [RegW-1:0] settings[4][2];
    settings = '{'{20'd1, 20'hFFFFF}, '{20'd604800, 20'd1},
                 '{20'hFFFFF, 20'hFFFFF}, '{20'd50, 20'd40}};
    for (int s = 0; s < 4; s++) begin
      write_bound(CfgMinTtl, settings[s][0]);
      write_bound(CfgMaxTtl, settings[s][1]);
      send_command(make_cmd(OpCreate, 64'h1000 + s, 32'd3, 32'd0, 47'd100));
      send_command(make_cmd(OpCreate, 64'h2000 + s, 32'd3, 32'hFFFF_FFFF, 47'd100));
      send_command(make_cmd(OpCreate, 64'h3000 + s, 32'd3, 32'd45, 47'd100));
      send_command(make_cmd(OpCount, 64'h0, 32'd0, 32'd0, 47'd146));
      send_command(make_cmd(OpPurge, 64'h0, 32'd0, 32'd0, 47'd700000));
      send_command(make_cmd(OpRevoke, 64'h0, 32'd3, 32'd0, 47'd700000));
      wait_drained();
    end
    write_bound(CfgMinTtl, MinTtlReset);
    write_bound(CfgMaxTtl, MaxTtlReset);
  endtask

  // Fills every slot, then checks the full table, reuse of a freed slot and
  // counts at the table's size.
  task automatic test_full_table();
    for (int i = 0; i < Entries; i++) begin
      send_command(make_cmd(OpCreate, 64'hA000_0000 + i, 32'd11 + (i % 2),
                            32'd1000 + i, 47'd5000));
    end
    send_command(make_cmd(OpCreate, 64'hBEEF, 32'd4, 32'd10, 47'd5000));
    send_command(make_cmd(OpCreate, 64'hA000_0000, 32'd4, 32'd10, 47'd5000));
    send_command(make_cmd(OpDestroy, 64'hA000_0010, 32'd0, 32'd0, 47'd5000));
    send_command(make_cmd(OpCreate, 64'hBEEF, 32'd4, 32'd10, 47'd5000));
    send_command(make_cmd(OpCount, 64'h0, 32'd0, 32'd0, 47'd5001));
    send_command(make_cmd(OpRevoke, 64'h0, 32'd12, 32'd0, 47'd5001));
    send_command(make_cmd(OpPurge, 64'h0, 32'd0, 32'd0, 47'd6500));
    send_command(make_cmd(OpCount, 64'h0, 32'd0, 32'd0, 47'd6500));
    send_command(make_cmd(OpPurge, 64'h0, 32'd0, 32'd0, '1));
    wait_drained();
  endtask

  function automatic set_req_t random_command();
    set_req_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 32) r.opcode = OpCreate;
    else if (pick < 46) r.opcode = OpValidate;
    else if (pick < 60) r.opcode = OpRefresh;
    else if (pick < 70) r.opcode = OpDestroy;
    else if (pick < 78) r.opcode = OpPurge;
    else if (pick < 87) r.opcode = OpRevoke;
    else if (pick < 97) r.opcode = OpCount;
    else r.opcode = OpUnused;
    r.session_token = ($urandom_range(99) < 6) ? {$urandom, $urandom}
                                                : tok_pool[$urandom_range(TokPool - 1)];
    r.user_number = ($urandom_range(99) < 4) ? 32'd0
                                             : usr_pool[$urandom_range(UsrPool - 1)];
    pick = $urandom_range(99);
    if (pick < 75) r.lifetime = $urandom_range(0, 60);
    else if (pick < 85) r.lifetime = $urandom;
    else if (pick < 92) r.lifetime = {12'd0, ttl_floor} + $urandom_range(0, 2) - 1;
    else r.lifetime = {12'd0, ttl_ceil} + $urandom_range(0, 2) - 1;
    // Time mostly creeps forward; rare jumps reach the upper bits and
    // occasionally step backwards.
    pick = $urandom_range(999);
    if (pick < 8) clock_now = {$urandom, $urandom} & 47'h7FFF_FFFF_FFFF;
    else if (pick < 12) clock_now = 47'h7FFF_FFFF_FFFF - $urandom_range(0, 40);
    else if (pick < 20) clock_now = clock_now - $urandom_range(1, 20);
    else clock_now = clock_now + $urandom_range(0, 12);
    r.current_time = clock_now;
    return r;
  endfunction

  task automatic test_random(int count, int pct, logic [RegW-1:0] lo,
                             logic [RegW-1:0] hi);
    write_bound(CfgMinTtl, lo);
    write_bound(CfgMaxTtl, hi);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      send_command(random_command());
      // Halfway through, the sender holds off until the block has answered
      // everything it was given.
      if (i == count / 2) begin
        start_i <= 1'b0;
        wait (pending_rsp.size() == 0);
        @(posedge clk_i);
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < TokPool; i++) tok_pool[i] = {$urandom, $urandom};
    tok_pool[0] = '0;
    tok_pool[1] = '1;
    for (int i = 0; i < UsrPool; i++) usr_pool[i] = $urandom;
    usr_pool[0] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 16;
    test_directed();
    test_ttl_bounds();
    idle_pct = 0;
    test_full_table();
    test_random(195, 16, 20'd1, 20'd30);
    test_random(195, 80, 20'd10, 20'd8);
    test_random(195, 0, 20'd1, MaxTtlReset);
    // A full command takes about one table sweep; allow two.
    repeat (2 * Entries + 20) @(posedge clk_i);
    if (fail_count == 0 && pending_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Well over ten times the slowest expected run.
  initial begin
    #400_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/set_pkg.sv
rtl/set_store.sv
rtl/session_expiry_table.sv
dv/tb_session_expiry_table.sv
